FILE: rtl/core/tlq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlq_pkg;

    localparam int COORD_BITS_DEF  = 32;
    localparam int LINE_W_BITS     = 31;
    localparam int COLOR_BITS      = 16;
    localparam int CORNER_IDX_BITS = 2;

    // Corner order within one quad.
    localparam logic [CORNER_IDX_BITS-1:0] CORNER_START_MINUS = 2'd0;
    localparam logic [CORNER_IDX_BITS-1:0] CORNER_START_PLUS  = 2'd1;
    localparam logic [CORNER_IDX_BITS-1:0] CORNER_END_MINUS   = 2'd2;
    localparam logic [CORNER_IDX_BITS-1:0] CORNER_END_PLUS    = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/tlq_seg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tlq_seg_if
    import tlq_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [COORD_BITS-1:0]  start_x;
    logic [COORD_BITS-1:0]  start_y;
    logic [COORD_BITS-1:0]  end_x;
    logic [COORD_BITS-1:0]  end_y;
    logic [LINE_W_BITS-1:0] line_width;
    logic [COLOR_BITS-1:0]  red_in;
    logic [COLOR_BITS-1:0]  green_in;
    logic [COLOR_BITS-1:0]  blue_in;

    modport source (
        output valid, start_x, start_y, end_x, end_y, line_width,
               red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, end_x, end_y, line_width,
               red_in, green_in, blue_in,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/tlq_corner_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tlq_corner_if
    import tlq_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                       valid;
    logic                       ready;
    logic [COORD_BITS-1:0]      corner_x;
    logic [COORD_BITS-1:0]      corner_y;
    logic [COLOR_BITS-1:0]      red_out;
    logic [COLOR_BITS-1:0]      green_out;
    logic [COLOR_BITS-1:0]      blue_out;
    logic [CORNER_IDX_BITS-1:0] corner_index;
    logic                       last_corner;

    modport source (
        output valid, corner_x, corner_y, red_out, green_out, blue_out,
               corner_index, last_corner,
        input  ready
    );
    modport sink (
        input  valid, corner_x, corner_y, red_out, green_out, blue_out,
               corner_index, last_corner,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/tlq_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tlq_front
    import tlq_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int CB    = COORD_BITS,
    localparam int WB    = LINE_W_BITS,
    localparam int MB    = WB + CB,
    localparam int TW    = 2 * MB,
    localparam int SW    = 2 * CB + 1,
    localparam int SIDEW = 4 * CB + 3 * COLOR_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    tlq_seg_if.sink          i_seg,
    output logic             o_valid,
    output logic [SW-1:0]    o_sum_sq,
    output logic [TW-1:0]    o_t_a,
    output logic [TW-1:0]    o_t_b,
    output logic [SIDEW-1:0] o_side
);
    localparam int HB = (MB + 1) / 2;
    localparam int LB = MB - HB;

    // Stage 0: input register.
    logic                  r_f0_valid;
    logic [CB-1:0]         r_f0_sx, r_f0_sy, r_f0_ex, r_f0_ey;
    logic [WB-1:0]         r_f0_w;
    logic [3*COLOR_BITS-1:0] r_f0_rgb;

    // Stage 1: differences and the two numerators.
    logic                  r_f1_valid;
    logic [CB-1:0]         r_f1_na, r_f1_nb;
    logic [WB-1:0]         r_f1_w;
    logic [SIDEW-1:0]      r_f1_side;

    // Stage 2: products.
    logic                  r_f2_valid;
    logic [MB-1:0]         r_f2_wa, r_f2_wb;
    logic [2*CB-1:0]       r_f2_aa, r_f2_bb;
    logic [SIDEW-1:0]      r_f2_side;

    // Stage 3: partial products of the squares.
    logic                  r_f3_valid;
    logic [SW-1:0]         r_f3_sum;
    logic [2*HB-1:0]       r_f3_ll [2];
    logic [MB-1:0]         r_f3_lh [2];
    logic [2*LB-1:0]       r_f3_hh [2];
    logic [SIDEW-1:0]      r_f3_side;

    // Stage 4: squared targets.
    logic                  r_f4_valid;
    logic [TW-1:0]         r_f4_t [2];
    logic [SW-1:0]         r_f4_sum;
    logic [SIDEW-1:0]      r_f4_side;

    logic [CB:0]   dxs, dys;
    logic          dx_zero, dy_zero;
    logic [CB-1:0] abs_x, abs_y;
    logic [CB-1:0] n_na, n_nb;
    logic          n_neg;
    logic [SW-1:0] sum_raw;
    logic [MB-1:0] wn [2];

    assign i_seg.ready = i_en;

    always_comb begin
        dxs     = {r_f0_sx[CB-1], r_f0_sx} - {r_f0_ex[CB-1], r_f0_ex};
        dys     = {r_f0_sy[CB-1], r_f0_sy} - {r_f0_ey[CB-1], r_f0_ey};
        dx_zero = (dxs == '0);
        dy_zero = (dys == '0);
        abs_x   = dxs[CB] ? CB'(~dxs + 1'b1) : dxs[CB-1:0];
        abs_y   = dys[CB] ? CB'(~dys + 1'b1) : dys[CB-1:0];
        // Axis-aligned and degenerate lines reuse the general path with a
        // unit numerator so the root stages give the full width or zero.
        if (dx_zero && dy_zero) begin
            n_na = '0;
            n_nb = '0;
        end else if (dx_zero) begin
            n_na = CB'(1);
            n_nb = '0;
        end else if (dy_zero) begin
            n_na = '0;
            n_nb = CB'(1);
        end else begin
            n_na = abs_y;
            n_nb = abs_x;
        end
        n_neg   = !dx_zero && !dy_zero && (dxs[CB] == dys[CB]);
        sum_raw = SW'(r_f2_aa) + SW'(r_f2_bb);
        wn[0]   = r_f2_wa;
        wn[1]   = r_f2_wb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_valid <= 1'b0;
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
            r_f4_valid <= 1'b0;
        end else if (i_en) begin
            r_f0_valid <= i_seg.valid;
            r_f1_valid <= r_f0_valid;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
            r_f4_valid <= r_f3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f0_sx  <= i_seg.start_x;
            r_f0_sy  <= i_seg.start_y;
            r_f0_ex  <= i_seg.end_x;
            r_f0_ey  <= i_seg.end_y;
            r_f0_w   <= i_seg.line_width;
            r_f0_rgb <= {i_seg.red_in, i_seg.green_in, i_seg.blue_in};

            r_f1_na   <= n_na;
            r_f1_nb   <= n_nb;
            r_f1_w    <= r_f0_w;
            r_f1_side <= {n_neg, r_f0_sx, r_f0_sy, r_f0_ex, r_f0_ey, r_f0_rgb};

            r_f2_wa   <= MB'(r_f1_w) * MB'(r_f1_na);
            r_f2_wb   <= MB'(r_f1_w) * MB'(r_f1_nb);
            r_f2_aa   <= (2*CB)'(r_f1_na) * (2*CB)'(r_f1_na);
            r_f2_bb   <= (2*CB)'(r_f1_nb) * (2*CB)'(r_f1_nb);
            r_f2_side <= r_f1_side;

            // A zero-length line has both numerators zero; a unit sum keeps
            // the root recurrence from running away.
            r_f3_sum  <= (sum_raw == '0) ? SW'(1) : sum_raw;
            for (int l = 0; l < 2; l++) begin
                r_f3_ll[l] <= (2*HB)'(wn[l][HB-1:0]) * (2*HB)'(wn[l][HB-1:0]);
                r_f3_lh[l] <= MB'(wn[l][HB-1:0]) * MB'(wn[l][MB-1:HB]);
                r_f3_hh[l] <= (2*LB)'(wn[l][MB-1:HB]) * (2*LB)'(wn[l][MB-1:HB]);
            end
            r_f3_side <= r_f2_side;

            for (int l = 0; l < 2; l++) begin
                r_f4_t[l] <= (TW'(r_f3_hh[l]) << (2 * HB))
                           + (TW'(r_f3_lh[l]) << (HB + 1))
                           + TW'(r_f3_ll[l]);
            end
            r_f4_sum  <= r_f3_sum;
            r_f4_side <= r_f3_side;
        end
    end

    assign o_valid  = r_f4_valid;
    assign o_sum_sq = r_f4_sum;
    assign o_t_a    = r_f4_t[0];
    assign o_t_b    = r_f4_t[1];
    assign o_side   = r_f4_side;

endmodule

`default_nettype wire

FILE: rtl/core/tlq_root.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-per-stage integer root: finds the largest g with g*g*S <= T for two
// lanes, keeping R = T - g*g*S and P = g*S so each stage is adds only.
module tlq_root
    import tlq_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int CB    = COORD_BITS,
    localparam int WB    = LINE_W_BITS,
    localparam int TW    = 2 * (WB + CB),
    localparam int SW    = 2 * CB + 1,
    localparam int SIDEW = 4 * CB + 3 * COLOR_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SW-1:0]    i_sum_sq,
    input  logic [TW-1:0]    i_t_a,
    input  logic [TW-1:0]    i_t_b,
    input  logic [SIDEW-1:0] i_side,
    output logic             o_valid,
    output logic [WB-1:0]    o_g_a,
    output logic [WB-1:0]    o_g_b,
    output logic [SIDEW-1:0] o_side
);
    localparam int PW = WB + SW;
    localparam int XW = 2 * WB + SW + 1;
    localparam int DW = XW + 2;

    logic             r_vld  [WB];
    logic [TW-1:0]    r_rem  [WB][2];
    logic [PW-1:0]    r_prod [WB][2];
    logic [WB-1:0]    r_g    [WB][2];
    logic [SW-1:0]    r_sum  [WB];
    logic [SIDEW-1:0] r_side [WB];

    for (genvar j = 0; j < WB; j++) begin : g_bit
        localparam int K = WB - 1 - j;

        logic             vld_in;
        logic [TW-1:0]    rem_in  [2];
        logic [PW-1:0]    prod_in [2];
        logic [WB-1:0]    g_in    [2];
        logic [SW-1:0]    sum_in;
        logic [SIDEW-1:0] side_in;
        logic [DW-1:0]    d       [2];
        logic             take    [2];

        if (j == 0) begin : g_first
            assign vld_in     = i_valid;
            assign rem_in[0]  = i_t_a;
            assign rem_in[1]  = i_t_b;
            assign prod_in[0] = '0;
            assign prod_in[1] = '0;
            assign g_in[0]    = '0;
            assign g_in[1]    = '0;
            assign sum_in     = i_sum_sq;
            assign side_in    = i_side;
        end else begin : g_next
            assign vld_in     = r_vld[j-1];
            assign rem_in[0]  = r_rem[j-1][0];
            assign rem_in[1]  = r_rem[j-1][1];
            assign prod_in[0] = r_prod[j-1][0];
            assign prod_in[1] = r_prod[j-1][1];
            assign g_in[0]    = r_g[j-1][0];
            assign g_in[1]    = r_g[j-1][1];
            assign sum_in     = r_sum[j-1];
            assign side_in    = r_side[j-1];
        end

        // Setting bit K grows g*g*S by 2^(K+1)*P + 2^(2K)*S.
        always_comb begin
            for (int l = 0; l < 2; l++) begin
                d[l]    = DW'(rem_in[l]) - (DW'(prod_in[l]) << (K + 1))
                        - (DW'(sum_in) << (2 * K));
                take[l] = !d[l][DW-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[j][l]  <= take[l] ? d[l][TW-1:0] : rem_in[l];
                    r_prod[j][l] <= take[l] ? prod_in[l] + (PW'(sum_in) << K)
                                            : prod_in[l];
                    r_g[j][l]    <= take[l] ? (g_in[l] | (WB'(1) << K)) : g_in[l];
                end
                r_sum[j]  <= sum_in;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[WB-1];
    assign o_g_a   = r_g[WB-1][0];
    assign o_g_b   = r_g[WB-1][1];
    assign o_side  = r_side[WB-1];

endmodule

`default_nettype wire

FILE: rtl/core/tlq_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module tlq_emit
    import tlq_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int CB    = COORD_BITS,
    localparam int WB    = LINE_W_BITS,
    localparam int SIDEW = 4 * CB + 3 * COLOR_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WB-1:0]    i_g_a,
    input  logic [WB-1:0]    i_g_b,
    input  logic [SIDEW-1:0] i_side,
    output logic             o_en,
    tlq_corner_if.source     o_corner
);
    localparam int C3   = 3 * COLOR_BITS;
    localparam int SUMW = ((CB > WB + 1) ? CB : WB + 1) + 1;
    localparam logic signed [SUMW-1:0] SAT_HI =
        {{(SUMW - CB + 1){1'b0}}, {(CB - 1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

    logic                    r_e0_valid;
    logic [WB:0]             r_e0_dx, r_e0_dy;
    logic [SIDEW-1:0]        r_e0_side;

    logic                    r_ser_valid;
    logic [CORNER_IDX_BITS-1:0] r_cnt;
    logic [CB-1:0]           r_cx [4];
    logic [CB-1:0]           r_cy [4];
    logic [C3-1:0]           r_rgb;

    logic [WB:0]   ga1, gb1;
    logic [WB:0]   n_dx, n_dy;
    logic          ser_take, load;
    logic [CB-1:0] sx, sy, ex, ey;

    function automatic logic [CB-1:0] sat_step(input logic [CB-1:0] p,
                                               input logic [WB:0]   d,
                                               input logic          sub);
        logic signed [SUMW-1:0] pe;
        logic signed [SUMW-1:0] de;
        logic signed [SUMW-1:0] v;
        pe = SUMW'($signed(p));
        de = SUMW'($signed(d));
        v  = sub ? pe - de : pe + de;
        if (v > SAT_HI) begin
            return SAT_HI[CB-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[CB-1:0];
        end
        return v[CB-1:0];
    endfunction

    // The root gives floor(w*n/L); halving with round-up gives the offset.
    always_comb begin
        ga1  = {1'b0, i_g_a} + 1'b1;
        gb1  = {1'b0, i_g_b} + 1'b1;
        n_dx = {1'b0, ga1[WB:1]};
        n_dy = i_side[SIDEW-1] ? (~{1'b0, gb1[WB:1]} + 1'b1) : {1'b0, gb1[WB:1]};
    end

    assign sx = r_e0_side[C3 + 3*CB +: CB];
    assign sy = r_e0_side[C3 + 2*CB +: CB];
    assign ex = r_e0_side[C3 + CB +: CB];
    assign ey = r_e0_side[C3 +: CB];

    assign ser_take = !r_ser_valid || (o_corner.ready && r_cnt == CORNER_END_PLUS);
    assign o_en     = !r_e0_valid || ser_take;
    assign load     = r_e0_valid && ser_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_valid  <= 1'b0;
            r_ser_valid <= 1'b0;
            r_cnt       <= CORNER_START_MINUS;
        end else begin
            if (o_en) begin
                r_e0_valid <= i_valid;
            end
            if (load) begin
                r_ser_valid <= 1'b1;
                r_cnt       <= CORNER_START_MINUS;
            end else if (r_ser_valid && o_corner.ready) begin
                if (r_cnt == CORNER_END_PLUS) begin
                    r_ser_valid <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_e0_dx   <= n_dx;
            r_e0_dy   <= n_dy;
            r_e0_side <= i_side;
        end
        if (load) begin
            r_cx[CORNER_START_MINUS] <= sat_step(sx, r_e0_dx, 1'b1);
            r_cx[CORNER_START_PLUS]  <= sat_step(sx, r_e0_dx, 1'b0);
            r_cx[CORNER_END_MINUS]   <= sat_step(ex, r_e0_dx, 1'b1);
            r_cx[CORNER_END_PLUS]    <= sat_step(ex, r_e0_dx, 1'b0);
            r_cy[CORNER_START_MINUS] <= sat_step(sy, r_e0_dy, 1'b1);
            r_cy[CORNER_START_PLUS]  <= sat_step(sy, r_e0_dy, 1'b0);
            r_cy[CORNER_END_MINUS]   <= sat_step(ey, r_e0_dy, 1'b1);
            r_cy[CORNER_END_PLUS]    <= sat_step(ey, r_e0_dy, 1'b0);
            r_rgb <= r_e0_side[C3-1:0];
        end
    end

    assign o_corner.valid        = r_ser_valid;
    assign o_corner.corner_x     = r_cx[r_cnt];
    assign o_corner.corner_y     = r_cy[r_cnt];
    assign o_corner.red_out      = r_rgb[2*COLOR_BITS +: COLOR_BITS];
    assign o_corner.green_out    = r_rgb[COLOR_BITS +: COLOR_BITS];
    assign o_corner.blue_out     = r_rgb[0 +: COLOR_BITS];
    assign o_corner.corner_index = r_cnt;
    assign o_corner.last_corner  = (r_cnt == CORNER_END_PLUS);

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ser_valid && !o_corner.ready) |=> (r_ser_valid && $stable(r_cnt)))
        else $error("corner index moved while the receiver stalled");

    a_step_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ser_valid && o_corner.ready && r_cnt != CORNER_END_PLUS)
        |=> (r_ser_valid && r_cnt == $past(r_cnt) + 2'd1))
        else $error("corner index did not advance after a taken corner");

    a_freeze_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en |-> (r_e0_valid && r_ser_valid))
        else $error("pipeline frozen without a pending quad");

endmodule

`default_nettype wire

FILE: rtl/core/thick_line_quad_expand_top.sv
// Thick-line quad expander.
// i_seg takes one line segment per item: two endpoints, a line width and a
// color. o_corner gives four items per segment, the quad corners in the
// order start minus offset, start plus offset, end minus offset, end plus
// offset; the fourth carries last_corner. Both channels use valid/ready.
// A segment passes through 5 front stages (differences, products, squares),
// one stage per line-width bit (31) of the root unit, and two output stages
// before its first corner appears. Sustained throughput is one segment per
// quad, set by the corner serializer that sends one corner per cycle while
// the receiver is ready; segments enter back to back while the pipeline
// has room, even while a quad is still being sent.
// Reset clears every valid bit; the block accepts items on the next cycle.
// When the receiver stalls and the last stage holds a segment waiting for
// the serializer, the whole pipeline holds in place and i_seg ready drops;
// nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module thick_line_quad_expand_top
    import tlq_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlq_seg_if.sink       i_seg,
    tlq_corner_if.source  o_corner
);
    localparam int CB    = COORD_BITS;
    localparam int WB    = LINE_W_BITS;
    localparam int TW    = 2 * (WB + CB);
    localparam int SW    = 2 * CB + 1;
    localparam int SIDEW = 4 * CB + 3 * COLOR_BITS + 1;

    logic             en;
    logic             front_valid;
    logic [SW-1:0]    front_sum;
    logic [TW-1:0]    front_t_a, front_t_b;
    logic [SIDEW-1:0] front_side;
    logic             root_valid;
    logic [WB-1:0]    root_g_a, root_g_b;
    logic [SIDEW-1:0] root_side;

    tlq_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_seg    (i_seg),
        .o_valid  (front_valid),
        .o_sum_sq (front_sum),
        .o_t_a    (front_t_a),
        .o_t_b    (front_t_b),
        .o_side   (front_side)
    );

    tlq_root #(.COORD_BITS(COORD_BITS)) u_root (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (front_valid),
        .i_sum_sq (front_sum),
        .i_t_a    (front_t_a),
        .i_t_b    (front_t_b),
        .i_side   (front_side),
        .o_valid  (root_valid),
        .o_g_a    (root_g_a),
        .o_g_b    (root_g_b),
        .o_side   (root_side)
    );

    tlq_emit #(.COORD_BITS(COORD_BITS)) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (root_valid),
        .i_g_a    (root_g_a),
        .i_g_b    (root_g_b),
        .i_side   (root_side),
        .o_en     (en),
        .o_corner (o_corner)
    );

endmodule

`default_nettype wire

FILE: test/thick_line_quad_expand_top_test.sv
`timescale 1ns / 1ps

module thick_line_quad_expand_top_test;
    import tlq_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int HOLD_LEN   = 300;
    localparam int WATCH_MAX  = 3000;
    localparam int DRAIN_WAIT = 60;

    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic [30:0] line_width;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } segment_t;

    typedef struct packed {
        logic [31:0]                corner_x;
        logic [31:0]                corner_y;
        logic [15:0]                red;
        logic [15:0]                green;
        logic [15:0]                blue;
        logic [CORNER_IDX_BITS-1:0] index;
        logic                       last;
    } corner_t;

    logic i_clk;
    logic i_rst_n;

    tlq_seg_if    seg_bus ();
    tlq_corner_if corner_bus ();

    thick_line_quad_expand_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seg    (seg_bus),
        .o_corner (corner_bus)
    );

    corner_t expected_corners[$];
    int      mismatch_count;
    int      corners_seen;
    int      segments_sent;
    bit      idle_on;
    bit      hold_req;
    bit      hold_ack;
    int      hold_cnt;
    int      stall_left;
    int      idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Exact round(w*num / (2*sqrt(sumsq))), ties rounding up: the largest q
    // with (2q-1)^2 * sumsq <= (w*num)^2.
    function automatic longint unsigned half_width_share(longint unsigned w,
            longint unsigned num, logic [255:0] sumsq);
        logic [255:0]    target;
        logic [255:0]    odd_sq;
        longint unsigned q;
        longint unsigned cand;
        q = 0;
        target = w * num;
        target = target * target;
        for (int bit_pos = 30; bit_pos >= 0; bit_pos--) begin
            cand = q | (64'd1 << bit_pos);
            if (cand <= (64'd1 << 30)) begin
                odd_sq = 2 * cand - 1;
                odd_sq = odd_sq * odd_sq;
                if (odd_sq * sumsq <= target) q = cand;
            end
        end
        return q;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void predict_quad(segment_t s);
        longint          sx;
        longint          sy;
        longint          ex;
        longint          ey;
        longint          dxs;
        longint          dys;
        longint          off_x;
        longint          off_y;
        longint          px;
        longint          py;
        longint unsigned w;
        longint unsigned abs_dy;
        longint unsigned abs_dx;
        logic [255:0]    sumsq;
        corner_t         c;
        sx = longint'($signed(s.start_x));
        sy = longint'($signed(s.start_y));
        ex = longint'($signed(s.end_x));
        ey = longint'($signed(s.end_y));
        w = s.line_width;
        dxs = sx - ex;
        dys = sy - ey;
        off_x = 0;
        off_y = 0;
        if (dxs == 0 && dys == 0) begin
            off_x = 0;
        end else if (dxs == 0) begin
            off_x = longint'((w + 1) >> 1);
        end else if (dys == 0) begin
            off_y = longint'((w + 1) >> 1);
        end else begin
            abs_dy = (dys < 0) ? -dys : dys;
            abs_dx = (dxs < 0) ? -dxs : dxs;
            sumsq = abs_dy;
            sumsq = sumsq * sumsq;
            sumsq = sumsq + 256'(abs_dx) * 256'(abs_dx);
            off_x = longint'(half_width_share(w, abs_dy, sumsq));
            off_y = longint'(half_width_share(w, abs_dx, sumsq));
            // Same-sign differences put the offset below the line.
            if ((dxs < 0) == (dys < 0)) off_y = -off_y;
        end
        for (int k = 0; k < 4; k++) begin
            px = (k < 2) ? sx : ex;
            py = (k < 2) ? sy : ey;
            if (k % 2 == 1) begin
                c.corner_x = 32'(clamp_coord(px + off_x));
                c.corner_y = 32'(clamp_coord(py + off_y));
            end else begin
                c.corner_x = 32'(clamp_coord(px - off_x));
                c.corner_y = 32'(clamp_coord(py - off_y));
            end
            c.red = s.red;
            c.green = s.green;
            c.blue = s.blue;
            c.index = CORNER_IDX_BITS'(k);
            c.last = (k == 3);
            expected_corners.push_back(c);
        end
    endfunction

    // Sends one item; valid stays high afterwards unless the caller drops it.
    task automatic send_segment(segment_t s);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            seg_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        seg_bus.valid      <= 1'b1;
        seg_bus.start_x    <= s.start_x;
        seg_bus.start_y    <= s.start_y;
        seg_bus.end_x      <= s.end_x;
        seg_bus.end_y      <= s.end_y;
        seg_bus.line_width <= s.line_width;
        seg_bus.red_in     <= s.red;
        seg_bus.green_in   <= s.green;
        seg_bus.blue_in    <= s.blue;
        do @(posedge i_clk); while (!seg_bus.ready);
        predict_quad(s);
        segments_sent++;
    endtask

    task automatic send_line(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
            logic [31:0] ey, logic [30:0] w, logic [15:0] r, logic [15:0] g,
            logic [15:0] b);
        segment_t s;
        s = '{sx, sy, ex, ey, w, r, g, b};
        send_segment(s);
    endtask

    task automatic wait_for_drain();
        seg_bus.valid <= 1'b0;
        while (expected_corners.size() != 0) @(posedge i_clk);
    endtask

    function automatic segment_t random_segment();
        segment_t s;
        int       shape;
        s.start_x = $urandom;
        s.start_y = $urandom;
        s.end_x = $urandom;
        s.end_y = $urandom;
        shape = $urandom_range(0, 19);
        if (shape < 6) begin
            // Small coordinates keep corners away from the saturation limits.
            s.start_x = 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
            s.start_y = 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
            s.end_x = 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
            s.end_y = 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
        end
        if (shape == 10 || shape == 11) s.end_x = s.start_x;
        if (shape == 12 || shape == 13) s.end_y = s.start_y;
        if (shape == 14) begin
            s.end_x = s.start_x;
            s.end_y = s.start_y;
        end
        if (shape == 15) s.end_x = s.start_x + $urandom_range(0, 2) - 1;
        case ($urandom_range(0, 3))
            0: s.line_width = 31'($urandom_range(0, 15));
            1: s.line_width = 31'($urandom_range(0, 2 ** 20));
            default: s.line_width = 31'($urandom);
        endcase
        s.red = 16'($urandom);
        s.green = 16'($urandom);
        s.blue = 16'($urandom);
        return s;
    endfunction

    task automatic test_directed();
        send_line(32'd100, 32'd200, 32'd100, 32'd200, 31'h7fffffff, 16'hffff, 16'h0, 16'hffff);
        send_line(32'h10000, 32'h0, 32'h10000, 32'h50000, 31'h30000, 16'h1234, 16'h5678, 16'h9abc);
        send_line(32'h0, 32'h20000, 32'h70000, 32'h20000, 31'd3, 16'h0, 16'hffff, 16'h0);
        send_line(32'd0, 32'd0, 32'd3, 32'd4, 31'd10, 16'd1, 16'd2, 16'd3);
        send_line(32'd0, 32'd0, -32'd3, 32'd4, 31'd10, 16'd4, 16'd5, 16'd6);
        send_line(32'd0, 32'd0, 32'd3, -32'd4, 31'd10, 16'd7, 16'd8, 16'd9);
        send_line(32'd0, 32'd0, -32'd3, -32'd4, 31'd10, 16'd10, 16'd11, 16'd12);
        send_line(32'd5, 32'd5, 32'd6, 32'd6, 31'd1, 16'd0, 16'd0, 16'd0);
        send_line(32'd0, 32'd0, 32'd0, 32'd7, 31'd1, 16'hffff, 16'hffff, 16'hffff);
        send_line(32'd0, 32'd0, 32'd1, 32'd1, 31'd0, 16'hffff, 16'hffff, 16'hffff);
        send_line(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0, 31'h7fffffff,
                  16'h8000, 16'h0001, 16'h7fff);
        send_line(32'h80000000, 32'h0, 32'h7fffffff, 32'h0, 31'h7fffffff,
                  16'h0001, 16'h8000, 16'hfffe);
        send_line(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                  16'h00ff, 16'hff00, 16'h0f0f);
        send_line(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 31'h7fffffff,
                  16'haaaa, 16'h5555, 16'hffff);
        send_line(32'h80000000, 32'h80000000, 32'h80000001, 32'h7fffffff, 31'h7ffffffe,
                  16'h5555, 16'haaaa, 16'h0);
        send_line(32'h7fffffff, 32'h0, 32'h7ffffffe, 32'h1, 31'h55555555,
                  16'h1, 16'h1, 16'h1);
        send_line(32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 31'h2aaaaaaa,
                  16'hfffe, 16'hfffe, 16'hfffe);
        wait_for_drain();
    endtask

    task automatic test_random(int count);
        repeat (count) send_segment(random_segment());
    endtask

    // The receiver holds off while items keep coming, so the input must stall.
    task automatic test_backpressure();
        hold_req <= ~hold_req;
        repeat (24) send_segment(random_segment());
        wait_for_drain();
    endtask

    initial begin
        seg_bus.valid      <= 1'b0;
        seg_bus.start_x    <= '0;
        seg_bus.start_y    <= '0;
        seg_bus.end_x      <= '0;
        seg_bus.end_y      <= '0;
        seg_bus.line_width <= '0;
        seg_bus.red_in     <= '0;
        seg_bus.green_in   <= '0;
        seg_bus.blue_in    <= '0;
        hold_req           <= 1'b0;
        idle_on            = 1'b1;
        mismatch_count     = 0;
        corners_seen       = 0;
        segments_sent      = 0;
        i_rst_n            <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        test_backpressure();
        test_random(150);
        wait_for_drain();
        idle_on = 1'b0;
        test_random(60);
        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Sent %0d segments and checked %0d corners: axis-aligned, degenerate,",
                 segments_sent, corners_seen);
        $display("saturating and general lines, with random idling and a long stall.");
        if (mismatch_count == 0 && expected_corners.size() == 0) begin
            $display("PASS thick_line_quad_expand_top");
        end else begin
            $display("FAIL thick_line_quad_expand_top");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            corner_bus.ready <= 1'b0;
            hold_ack <= 1'b0;
            hold_cnt <= 0;
            stall_left <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cnt <= HOLD_LEN;
            corner_bus.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            corner_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            corner_bus.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 12);
            corner_bus.ready <= 1'b0;
        end else begin
            corner_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        corner_t got;
        corner_t want;
        if (i_rst_n && corner_bus.valid && corner_bus.ready) begin
            got = '{corner_bus.corner_x, corner_bus.corner_y, corner_bus.red_out,
                    corner_bus.green_out, corner_bus.blue_out, corner_bus.corner_index,
                    corner_bus.last_corner};
            corners_seen++;
            if (expected_corners.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected corner x=%h y=%h idx=%0d", got.corner_x,
                             got.corner_y, got.index);
            end else begin
                want = expected_corners.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("corner mismatch exp x=%h y=%h rgb=%h/%h/%h idx=%0d last=%b",
                                 want.corner_x, want.corner_y, want.red, want.green,
                                 want.blue, want.index, want.last);
                        $display("                got x=%h y=%h rgb=%h/%h/%h idx=%0d last=%b",
                                 got.corner_x, got.corner_y, got.red, got.green,
                                 got.blue, got.index, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (seg_bus.valid && seg_bus.ready)
                || (corner_bus.valid && corner_bus.ready)) begin
            idle_cycles <= 0;
        end else if (seg_bus.valid || expected_corners.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_MAX) begin
                $display("FAIL thick_line_quad_expand_top");
                $finish;
            end
        end
    end

endmodule
